// ===== hdl/qpe_pkg.sv =====
`default_nettype none

package qpe_pkg;

    // Field formats
    localparam int RADIUS_WIDTH    = 24;
    localparam int VALUE_WIDTH     = 32;
    localparam int RADIUS_FRAC     = 20;
    localparam int VALUE_FRAC      = 24;
    localparam int CFG_WIDTH       = (VALUE_WIDTH > RADIUS_WIDTH) ? VALUE_WIDTH : RADIUS_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;

    // Exponential unit constants
    localparam int              EXP_TERMS = 13;
    localparam logic [31:0]     LN2_Q32   = 32'd2977044472;
    localparam logic [63:0]     TWO_POW32 = 64'h1_0000_0000;

    // Reciprocals of the series divisors 2 .. EXP_TERMS, floor(2^32 / k)
    localparam logic [31:0] TAYLOR_RECIP [EXP_TERMS-1] = '{
        32'(TWO_POW32 / 2),  32'(TWO_POW32 / 3),  32'(TWO_POW32 / 4),
        32'(TWO_POW32 / 5),  32'(TWO_POW32 / 6),  32'(TWO_POW32 / 7),
        32'(TWO_POW32 / 8),  32'(TWO_POW32 / 9),  32'(TWO_POW32 / 10),
        32'(TWO_POW32 / 11), 32'(TWO_POW32 / 12), 32'(TWO_POW32 / 13)
    };

    // Register map
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_COULOMB    = 3'd0,
        CFG_LINEAR     = 3'd1,
        CFG_OFFSET     = 3'd2,
        CFG_GAUSS_AMP  = 3'd3,
        CFG_GAUSS_RATE = 3'd4,
        CFG_MIN_RADIUS = 3'd5
    } t_cfg_index;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;

    // One clipped term and its overflow flag
    typedef struct packed {
        logic   sat;
        t_value value;
    } t_term;

    localparam int MAG_WIDTH = VALUE_WIDTH + 5;

    localparam logic [MAG_WIDTH-1:0] NEG_MAG   = MAG_WIDTH'(1) << (VALUE_WIDTH - 1);
    localparam logic [MAG_WIDTH-1:0] POS_MAX   = NEG_MAG - MAG_WIDTH'(1);
    localparam t_value               VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam t_value               VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // Apply sign to a magnitude and clip to the signed value range
    function automatic t_term clip_term(input logic neg, input logic [MAG_WIDTH-1:0] mag);
        t_term res;
        res.sat   = 1'b0;
        res.value = '0;
        if (neg) begin
            if (mag > NEG_MAG) begin
                res.sat   = 1'b1;
                res.value = VALUE_MIN;
            end else begin
                res.value = VALUE_WIDTH'(~mag + MAG_WIDTH'(1));
            end
        end else if (mag > POS_MAX) begin
            res.sat   = 1'b1;
            res.value = VALUE_MAX;
        end else begin
            res.value = VALUE_WIDTH'(mag);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/quark_potential_evaluator_unit.sv =====
// Quark pair potential evaluator: V = A/r + B*r + C + D*exp(-E*r*r) per radius.
// Input channel: i_in_valid / o_in_stall with i_radius (unsigned Q4.20 fm).
// Output channel: o_out_valid / i_out_stall with o_potential (signed Q8.24 GeV)
// and o_saturated, set when any term or the final sum was clipped.
// Coefficients A..E and the minimum Coulomb radius are loaded through
// i_cfg_we / i_cfg_index / i_cfg_data; the user must load them only while no
// item is in flight, which the block itself does not enforce.
// One item is accepted every cycle while o_in_stall is low. The depth is set
// by the exponential series (twelve terms, three stages each: multiply,
// reciprocal multiply, correction); the radix-2 Coulomb divider runs beside
// it, one quotient bit per stage.
// Reset clears all in-flight items and loads the register defaults: all
// coefficients zero and the minimum radius one LSB.
// When the receiver stalls, the waiting result moves into a one-entry skid
// register and the pipeline still takes that cycle's input; o_in_stall then
// rises and holds the pipeline until the skid register drains.
`default_nettype none

module quark_potential_evaluator_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [qpe_pkg::RADIUS_WIDTH-1:0]    i_radius,
    input  wire logic                                i_cfg_we,
    input  wire logic [qpe_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [qpe_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [qpe_pkg::VALUE_WIDTH-1:0]   o_potential,
    output logic                                     o_saturated
);

    import qpe_pkg::*;

    localparam int RW       = RADIUS_WIDTH;
    localparam int VW       = VALUE_WIDTH;
    localparam int RF       = RADIUS_FRAC;
    localparam int QB       = VW + 1;
    localparam int NUMW     = VW + RF;
    localparam int PLW      = VW + RW;
    localparam int XSW      = VW + 2 * RW + 1;
    localparam int XW       = VALUE_FRAC + 6;
    localparam int X_SHIFT  = 32 - VALUE_FRAC;
    localparam int ND_REMW  = XW + X_SHIFT + 2;
    localparam int NBITS    = 8;
    localparam int ND_BPS   = 2;
    localparam int ND_STAGES = NBITS / ND_BPS;
    localparam int TT_STAGES = 3 * (EXP_TERMS - 1);
    localparam int SUMW     = 34;
    localparam int GW       = 33;
    localparam int GSW      = 41;
    localparam int PGW      = VW + GW;
    localparam int TW       = VW + 3;
    localparam logic [NBITS-1:0] G_SHIFT_LIMIT = NBITS'(40);

    // Stage numbering
    localparam int S_IN  = 1;
    localparam int S_PRE = 2;
    localparam int S_MUL = 3;
    localparam int S_X   = 4;
    localparam int S_T0  = S_X + ND_STAGES + 1;
    localparam int S_G   = S_T0 + TT_STAGES + 1;
    localparam int S_GP  = S_G + 1;
    localparam int S_GT  = S_GP + 1;
    localparam int S_OUT = S_GT + 1;
    localparam int S_TC  = S_PRE + QB + 1;

    // Configuration registers
    logic [VW-1:0] r_cfg_coul;
    logic [VW-1:0] r_cfg_lin;
    logic [VW-1:0] r_cfg_off;
    logic [VW-1:0] r_cfg_gamp;
    logic [VW-1:0] r_cfg_grate;
    logic [RW-1:0] r_cfg_rmin;

    // Pipeline control
    logic            r_vld [S_IN:S_OUT];
    logic            r_sk_vld;
    t_value          r_sk_pot;
    logic            r_sk_sat;
    logic            w_adv;

    // Datapath registers
    logic [RW-1:0]   r_rad1;
    logic [2*RW-1:0] r_rr2;
    logic [PLW-1:0]  r_plin2;
    logic [RW-1:0]   r_dv_rem [0:QB];
    logic [QB-1:0]   r_dv_num [0:QB];
    logic [QB-1:0]   r_dv_q   [0:QB];
    logic [RW-1:0]   r_dv_div [0:QB];
    logic            r_dv_ov  [0:QB];
    logic            r_dv_cz  [0:QB];
    logic            r_dv_neg [0:QB];
    logic [PLW-1:0]  r_elo3;
    logic [PLW-1:0]  r_ehi3;
    t_term           r_tl [S_MUL:S_GT];
    logic [XW-1:0]   r_x4;
    logic            r_xbig4;
    logic [ND_REMW-1:0] r_nd_rem  [1:ND_STAGES];
    logic [NBITS-1:0]   r_nd_n    [1:ND_STAGES];
    logic               r_nd_xbig [1:ND_STAGES];
    logic [31:0]        r_tt_term [0:TT_STAGES];
    logic signed [SUMW-1:0] r_tt_sum [0:TT_STAGES];
    logic [31:0]        r_tt_f    [0:TT_STAGES];
    logic [31:0]        r_tt_pr   [0:TT_STAGES];
    logic [31:0]        r_tt_qe   [0:TT_STAGES];
    logic [NBITS-1:0]   r_tt_n    [0:TT_STAGES];
    logic               r_tt_xbig [0:TT_STAGES];
    logic [GW-1:0]   r_g46;
    logic [PGW-1:0]  r_pg47;
    t_term           r_tc [S_TC:S_GT];
    t_term           r_tg48;
    t_value          r_pot;
    logic            r_sat;

    // Next values
    logic [2*RW-1:0] n_rr2;
    logic [PLW-1:0]  n_plin2;
    logic [RW-1:0]   n_dv_rem [0:QB];
    logic [QB-1:0]   n_dv_num [0:QB];
    logic [QB-1:0]   n_dv_q   [0:QB];
    logic [RW-1:0]   n_dv_div [0:QB];
    logic            n_dv_ov  [0:QB];
    logic            n_dv_cz  [0:QB];
    logic            n_dv_neg [0:QB];
    logic [PLW-1:0]  n_elo3;
    logic [PLW-1:0]  n_ehi3;
    t_term           n_tl3;
    logic [XW-1:0]   n_x4;
    logic            n_xbig4;
    logic [ND_REMW-1:0] n_nd_rem  [1:ND_STAGES];
    logic [NBITS-1:0]   n_nd_n    [1:ND_STAGES];
    logic               n_nd_xbig [1:ND_STAGES];
    logic [31:0]        n_tt_term [0:TT_STAGES];
    logic signed [SUMW-1:0] n_tt_sum [0:TT_STAGES];
    logic [31:0]        n_tt_f    [0:TT_STAGES];
    logic [31:0]        n_tt_pr   [0:TT_STAGES];
    logic [31:0]        n_tt_qe   [0:TT_STAGES];
    logic [NBITS-1:0]   n_tt_n    [0:TT_STAGES];
    logic               n_tt_xbig [0:TT_STAGES];
    logic [GW-1:0]   n_g46;
    logic [PGW-1:0]  n_pg47;
    t_term           n_tc;
    t_term           n_tg48;
    t_value          n_pot;
    logic            n_sat;

    // Coefficient magnitudes
    logic            w_a_neg, w_b_neg, w_d_neg;
    logic [VW-1:0]   w_a_mag, w_b_mag, w_d_mag;

    assign w_a_neg = r_cfg_coul[VW-1];
    assign w_b_neg = r_cfg_lin[VW-1];
    assign w_d_neg = r_cfg_gamp[VW-1];
    assign w_a_mag = w_a_neg ? (~r_cfg_coul + 1'b1) : r_cfg_coul;
    assign w_b_mag = w_b_neg ? (~r_cfg_lin + 1'b1) : r_cfg_lin;
    assign w_d_mag = w_d_neg ? (~r_cfg_gamp + 1'b1) : r_cfg_gamp;

    // Advance the pipeline while the skid register is empty
    assign w_adv       = !r_sk_vld;
    assign o_in_stall  = r_sk_vld;
    assign o_out_valid = r_sk_vld | r_vld[S_OUT];
    assign o_potential = r_sk_vld ? r_sk_pot : r_pot;
    assign o_saturated = r_sk_vld ? r_sk_sat : r_sat;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_coul  <= '0;
            r_cfg_lin   <= '0;
            r_cfg_off   <= '0;
            r_cfg_gamp  <= '0;
            r_cfg_grate <= '0;
            r_cfg_rmin  <= RW'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_COULOMB:    r_cfg_coul  <= i_cfg_data[VW-1:0];
                CFG_LINEAR:     r_cfg_lin   <= i_cfg_data[VW-1:0];
                CFG_OFFSET:     r_cfg_off   <= i_cfg_data[VW-1:0];
                CFG_GAUSS_AMP:  r_cfg_gamp  <= i_cfg_data[VW-1:0];
                CFG_GAUSS_RATE: r_cfg_grate <= i_cfg_data[VW-1:0];
                CFG_MIN_RADIUS: r_cfg_rmin  <= i_cfg_data[RW-1:0];
                default: ;
            endcase
        end
    end

    // Front: square radius, linear product, divider setup
    always_comb begin
        logic [NUMW-1:0] v_num;
        n_rr2   = (2*RW)'(r_rad1) * (2*RW)'(r_rad1);
        n_plin2 = PLW'(w_b_mag) * PLW'(r_rad1);
        v_num   = {w_a_mag, {RF{1'b0}}} + NUMW'(r_rad1 >> 1);
        n_dv_rem[0] = RW'(v_num[NUMW-1:QB]);
        n_dv_num[0] = v_num[QB-1:0];
        n_dv_q[0]   = '0;
        n_dv_div[0] = r_rad1;
        n_dv_ov[0]  = 1'b0;
        n_dv_cz[0]  = (r_rad1 != '0) && (r_rad1 >= r_cfg_rmin);
        n_dv_neg[0] = w_a_neg;
    end

    // Coulomb divider: one quotient bit per stage
    always_comb begin
        logic [RW:0] v_t;
        logic        v_ge;
        for (int j = 1; j <= QB; j++) begin
            v_t  = {r_dv_rem[j-1], r_dv_num[j-1][QB-1]};
            v_ge = v_t >= {1'b0, r_dv_div[j-1]};
            n_dv_rem[j] = v_ge ? RW'(v_t - {1'b0, r_dv_div[j-1]}) : RW'(v_t);
            n_dv_num[j] = r_dv_num[j-1] << 1;
            n_dv_q[j]   = {r_dv_q[j-1][QB-2:0], v_ge};
            n_dv_div[j] = r_dv_div[j-1];
            n_dv_cz[j]  = r_dv_cz[j-1];
            n_dv_neg[j] = r_dv_neg[j-1];
            if (j == 1) begin
                n_dv_ov[j] = r_dv_rem[0] >= r_dv_div[0];
            end else begin
                n_dv_ov[j] = r_dv_ov[j-1];
            end
        end
    end

    // Coulomb term from the finished quotient
    always_comb begin
        n_tc.sat   = 1'b0;
        n_tc.value = '0;
        if (r_dv_cz[QB]) begin
            if (r_dv_ov[QB]) begin
                n_tc.sat   = 1'b1;
                n_tc.value = r_dv_neg[QB] ? VALUE_MIN : VALUE_MAX;
            end else begin
                n_tc = clip_term(r_dv_neg[QB], MAG_WIDTH'(r_dv_q[QB]));
            end
        end
    end

    // Gaussian argument products and linear term
    always_comb begin
        logic [PLW:0] v_lin;
        n_elo3 = PLW'(r_cfg_grate) * PLW'(r_rr2[RW-1:0]);
        n_ehi3 = PLW'(r_cfg_grate) * PLW'(r_rr2[2*RW-1:RW]);
        v_lin  = ((PLW+1)'(r_plin2) + ((PLW+1)'(1) << (RF - 1))) >> RF;
        n_tl3  = clip_term(w_b_neg, MAG_WIDTH'(v_lin));
    end

    // Round the Gaussian argument to Q.24
    always_comb begin
        logic [XSW-1:0] v_xs;
        v_xs    = XSW'(r_elo3) + (XSW'(r_ehi3) << RW) + (XSW'(1) << (2 * RF - 1));
        n_x4    = v_xs[XW+2*RF-1:2*RF];
        n_xbig4 = |v_xs[XSW-1:XW+2*RF];
    end

    // Split argument into n*ln2 + f, two quotient bits per stage
    always_comb begin
        logic [ND_REMW-1:0] v_rem;
        logic [ND_REMW-1:0] v_lim;
        logic [NBITS-1:0]   v_n;
        logic               v_big;
        int                 b;
        for (int s = 1; s <= ND_STAGES; s++) begin
            if (s == 1) begin
                v_rem = ND_REMW'({r_x4, {X_SHIFT{1'b0}}});
                v_n   = '0;
                v_big = r_xbig4;
            end else begin
                v_rem = r_nd_rem[s-1];
                v_n   = r_nd_n[s-1];
                v_big = r_nd_xbig[s-1];
            end
            for (int j = 0; j < ND_BPS; j++) begin
                b     = NBITS - 1 - (s - 1) * ND_BPS - j;
                v_lim = ND_REMW'(LN2_Q32) << b;
                if (v_rem >= v_lim) begin
                    v_rem    = v_rem - v_lim;
                    v_n[b]   = 1'b1;
                end
            end
            n_nd_rem[s]  = v_rem;
            n_nd_n[s]    = v_n;
            n_nd_xbig[s] = v_big;
        end
    end

    // Series for exp(-f): first term, then multiply, reciprocal, correct per term
    always_comb begin
        logic [35:0] v_qk;
        logic [35:0] v_rm;
        logic [31:0] v_term;
        int          k;
        n_tt_f[0]    = r_nd_rem[ND_STAGES][31:0];
        n_tt_term[0] = r_nd_rem[ND_STAGES][31:0];
        n_tt_sum[0]  = $signed((SUMW'(1) << 32) - SUMW'(r_nd_rem[ND_STAGES][31:0]));
        n_tt_pr[0]   = '0;
        n_tt_qe[0]   = '0;
        n_tt_n[0]    = r_nd_n[ND_STAGES];
        n_tt_xbig[0] = r_nd_xbig[ND_STAGES];
        for (int p = 1; p <= TT_STAGES; p++) begin
            k = 2 + (p - 1) / 3;
            n_tt_term[p] = r_tt_term[p-1];
            n_tt_sum[p]  = r_tt_sum[p-1];
            n_tt_f[p]    = r_tt_f[p-1];
            n_tt_pr[p]   = r_tt_pr[p-1];
            n_tt_qe[p]   = r_tt_qe[p-1];
            n_tt_n[p]    = r_tt_n[p-1];
            n_tt_xbig[p] = r_tt_xbig[p-1];
            if ((p - 1) % 3 == 0) begin
                n_tt_pr[p] = 32'((64'(r_tt_term[p-1]) * 64'(r_tt_f[p-1])) >> 32);
            end else if ((p - 1) % 3 == 1) begin
                n_tt_qe[p] = 32'((64'(r_tt_pr[p-1]) * 64'(TAYLOR_RECIP[k-2])) >> 32);
            end else begin
                v_qk   = 36'(r_tt_qe[p-1]) * 36'(k);
                v_rm   = 36'(r_tt_pr[p-1]) - v_qk;
                v_term = r_tt_qe[p-1] + 32'(v_rm >= 36'(k));
                n_tt_term[p] = v_term;
                if (k % 2 == 1) begin
                    n_tt_sum[p] = r_tt_sum[p-1] - $signed(SUMW'(v_term));
                end else begin
                    n_tt_sum[p] = r_tt_sum[p-1] + $signed(SUMW'(v_term));
                end
            end
        end
    end

    // Scale by 2^-n with rounding
    always_comb begin
        logic [GW-1:0]    v_e;
        logic [NBITS-1:0] v_n;
        v_e = r_tt_sum[TT_STAGES][GW-1:0];
        v_n = r_tt_n[TT_STAGES];
        if (r_tt_xbig[TT_STAGES] || v_n >= G_SHIFT_LIMIT) begin
            n_g46 = '0;
        end else if (v_n == '0) begin
            n_g46 = v_e;
        end else begin
            n_g46 = GW'((GSW'(v_e) + (GSW'(1) << (v_n - NBITS'(1)))) >> v_n);
        end
    end

    // Gaussian term
    always_comb begin
        logic [PGW:0] v_g;
        n_pg47 = PGW'(w_d_mag) * PGW'(r_g46);
        v_g    = ((PGW+1)'(r_pg47) + ((PGW+1)'(1) << 31)) >> 32;
        n_tg48 = clip_term(w_d_neg, MAG_WIDTH'(v_g));
    end

    // Final sum and clip
    always_comb begin
        logic signed [TW-1:0] v_total;
        v_total = TW'($signed(r_tc[S_GT].value)) + TW'($signed(r_tl[S_GT].value))
                + TW'($signed(r_cfg_off)) + TW'($signed(r_tg48.value));
        n_sat = r_tc[S_GT].sat | r_tl[S_GT].sat | r_tg48.sat;
        if (v_total > TW'(VALUE_MAX)) begin
            n_pot = VALUE_MAX;
            n_sat = 1'b1;
        end else if (v_total < TW'(VALUE_MIN)) begin
            n_pot = VALUE_MIN;
            n_sat = 1'b1;
        end else begin
            n_pot = VW'(v_total);
        end
    end

    // Valid bits and skid register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = S_IN; i <= S_OUT; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_sk_vld <= 1'b0;
        end else begin
            if (w_adv) begin
                r_vld[S_IN] <= i_in_valid;
                for (int i = S_IN + 1; i <= S_OUT; i++) begin
                    r_vld[i] <= r_vld[i-1];
                end
                if (r_vld[S_OUT] && i_out_stall) begin
                    r_sk_vld <= 1'b1;
                end
            end else if (!i_out_stall) begin
                r_sk_vld <= 1'b0;
            end
        end
    end

    // Hold the stalled result
    always_ff @(posedge i_clk) begin
        if (w_adv && r_vld[S_OUT] && i_out_stall) begin
            r_sk_pot <= r_pot;
            r_sk_sat <= r_sat;
        end
    end

    // Advance datapath registers
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rad1  <= i_radius;
            r_rr2   <= n_rr2;
            r_plin2 <= n_plin2;
            for (int j = 0; j <= QB; j++) begin
                r_dv_rem[j] <= n_dv_rem[j];
                r_dv_num[j] <= n_dv_num[j];
                r_dv_q[j]   <= n_dv_q[j];
                r_dv_div[j] <= n_dv_div[j];
                r_dv_ov[j]  <= n_dv_ov[j];
                r_dv_cz[j]  <= n_dv_cz[j];
                r_dv_neg[j] <= n_dv_neg[j];
            end
            r_elo3    <= n_elo3;
            r_ehi3    <= n_ehi3;
            r_tl[S_MUL] <= n_tl3;
            for (int i = S_MUL + 1; i <= S_GT; i++) begin
                r_tl[i] <= r_tl[i-1];
            end
            r_x4    <= n_x4;
            r_xbig4 <= n_xbig4;
            for (int s = 1; s <= ND_STAGES; s++) begin
                r_nd_rem[s]  <= n_nd_rem[s];
                r_nd_n[s]    <= n_nd_n[s];
                r_nd_xbig[s] <= n_nd_xbig[s];
            end
            for (int p = 0; p <= TT_STAGES; p++) begin
                r_tt_term[p] <= n_tt_term[p];
                r_tt_sum[p]  <= n_tt_sum[p];
                r_tt_f[p]    <= n_tt_f[p];
                r_tt_pr[p]   <= n_tt_pr[p];
                r_tt_qe[p]   <= n_tt_qe[p];
                r_tt_n[p]    <= n_tt_n[p];
                r_tt_xbig[p] <= n_tt_xbig[p];
            end
            r_g46  <= n_g46;
            r_pg47 <= n_pg47;
            r_tc[S_TC] <= n_tc;
            for (int i = S_TC + 1; i <= S_GT; i++) begin
                r_tc[i] <= r_tc[i-1];
            end
            r_tg48 <= n_tg48;
            r_pot  <= n_pot;
            r_sat  <= n_sat;
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_quark_potential_evaluator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tb_quark_potential_evaluator_unit;
    import qpe_pkg::*;

    localparam int        DRAIN_CYCLES = 60;
    localparam int        CYCLE_LIMIT  = 1000000;
    localparam logic [2:0] CFG_UNUSED  = 3'd6;
    localparam logic [63:0] TERM_CAP   = 64'd1 << 32;
    localparam logic [63:0] ARG_LIMIT  = 64'd64 << 24;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] potential;
        logic                   saturated;
    } t_energy;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [RADIUS_WIDTH-1:0]      i_radius;
    logic                         i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0]   i_cfg_index;
    logic [CFG_WIDTH-1:0]         i_cfg_data;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [VALUE_WIDTH-1:0] o_potential;
    logic                         o_saturated;

    quark_potential_evaluator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_radius    (i_radius),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_potential (o_potential),
        .o_saturated (o_saturated)
    );

    // Coefficient copies for the predictor
    logic [31:0] coul_a, lin_b, off_c, gamp_d, grate_e;
    logic [23:0] min_r;

    logic [RADIUS_WIDTH-1:0] pending_radii[$];
    t_energy                 expected_energy[$];
    bit                      in_took;
    bit                      quiet;
    bit                      hold_send;
    int                      send_gap;
    int                      stall_cnt;
    int                      error_count;
    int                      cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // round(a*b / 2^sh), capped
    function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b,
                                              input int sh, input logic [63:0] cap);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        if (p[127:64] != 64'd0 || p[63:0] > cap)
            return cap;
        return p[63:0];
    endfunction

    function automatic logic [63:0] abs_of(input logic [31:0] v);
        if (v[31])
            return 64'(-longint'(signed'(v)));
        return {32'd0, v};
    endfunction

    // Apply sign and clip to the 32-bit range
    function automatic longint clip_mag(input bit neg, input logic [63:0] mag,
                                        output bit clipped);
        clipped = 1'b0;
        if (neg) begin
            if (mag > (64'd1 << 31)) begin
                clipped = 1'b1;
                return -(longint'(1) << 31);
            end
            return -longint'(mag);
        end
        if (mag > ((64'd1 << 31) - 1)) begin
            clipped = 1'b1;
            return (longint'(1) << 31) - 1;
        end
        return longint'(mag);
    endfunction

    // exp(-x) for x in Q.24, result in Q0.32
    function automatic logic [63:0] gauss_factor(input logic [63:0] x);
        logic [63:0] x32, n, f, term, e;
        longint      sum;
        if (x >= ARG_LIMIT)
            return 64'd0;
        x32  = x << 8;
        n    = x32 / {32'd0, LN2_Q32};
        f    = x32 - n * {32'd0, LN2_Q32};
        sum  = longint'(1) << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= EXP_TERMS; k++) begin
            term = ((term * f) >> 32) / k;
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        e = 64'(sum);
        if (n == 0)
            return e;
        if (n >= 40)
            return 64'd0;
        return (e + (64'd1 << (n - 1))) >> n;
    endfunction

    function automatic t_energy pair_potential(input logic [RADIUS_WIDTH-1:0] r);
        logic [63:0] rr, mag, q, rem, x, g;
        longint      tc, tl, tk, tg, total;
        bit          sat, clipped;
        t_energy     res;
        rr  = {40'd0, r};
        sat = 1'b0;
        tc  = 0;
        // Coulomb term, dropped at zero radius and below the minimum
        if (rr != 0 && r >= min_r) begin
            mag = abs_of(coul_a);
            q   = mag / rr;
            rem = mag % rr;
            if (q > (TERM_CAP >> 20))
                mag = TERM_CAP;
            else begin
                mag = (q << 20) + ((rem << 20) + rr / 2) / rr;
                if (mag > TERM_CAP)
                    mag = TERM_CAP;
            end
            tc  = clip_mag(coul_a[31], mag, clipped);
            sat = sat | clipped;
        end
        tl  = clip_mag(lin_b[31], round_mul(abs_of(lin_b), rr, 20, TERM_CAP), clipped);
        sat = sat | clipped;
        tk  = longint'(signed'(off_c));
        x   = round_mul({32'd0, grate_e}, rr * rr, 40, ARG_LIMIT);
        g   = gauss_factor(x);
        tg  = clip_mag(gamp_d[31], round_mul(abs_of(gamp_d), g, 32, TERM_CAP), clipped);
        sat = sat | clipped;
        total = tc + tl + tk + tg;
        if (total > (longint'(1) << 31) - 1) begin
            total = (longint'(1) << 31) - 1;
            sat   = 1'b1;
        end else if (total < -(longint'(1) << 31)) begin
            total = -(longint'(1) << 31);
            sat   = 1'b1;
        end
        res.potential = total[31:0];
        res.saturated = sat;
        return res;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Capture transfers; predict on input, check on output
    always @(posedge i_clk) begin
        t_energy want;
        in_took <= i_in_valid && !o_in_stall && i_rst_n;
        if (i_rst_n && i_in_valid && !o_in_stall)
            expected_energy.push_back(pair_potential(i_radius));
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_energy.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result potential=%h saturated=%b",
                         $time, o_potential, o_saturated);
            end else begin
                want = expected_energy.pop_front();
                if (o_potential !== want.potential) begin
                    error_count++;
                    $display("%0t: potential expected %h actual %h",
                             $time, want.potential, o_potential);
                end
                if (o_saturated !== want.saturated) begin
                    error_count++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.saturated, o_saturated);
                end
            end
        end
    end

    // Feed radii from the pending queue
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_took)) begin
            if (send_gap > 0) begin
                i_in_valid <= 1'b0;
                send_gap   <= send_gap - 1;
            end else if (!hold_send && pending_radii.size() != 0) begin
                i_radius   <= pending_radii.pop_front();
                i_in_valid <= 1'b1;
                send_gap   <= pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Random backpressure on the result side
    always @(negedge i_clk) begin
        if (stall_cnt > 0) begin
            i_out_stall <= 1'b1;
            stall_cnt   <= stall_cnt - 1;
        end else begin
            i_out_stall <= 1'b0;
            stall_cnt   <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_COULOMB:    coul_a  = data;
            CFG_LINEAR:     lin_b   = data;
            CFG_OFFSET:     off_c   = data;
            CFG_GAUSS_AMP:  gamp_d  = data;
            CFG_GAUSS_RATE: grate_e = data;
            CFG_MIN_RADIUS: min_r   = data[23:0];
            default: ;
        endcase
    endtask

    task automatic load_coeffs(input logic [31:0] a, input logic [31:0] b,
                               input logic [31:0] c, input logic [31:0] d,
                               input logic [31:0] e, input logic [23:0] mr);
        write_reg(CFG_COULOMB, a);
        write_reg(CFG_LINEAR, b);
        write_reg(CFG_OFFSET, c);
        write_reg(CFG_GAUSS_AMP, d);
        write_reg(CFG_GAUSS_RATE, e);
        write_reg(CFG_MIN_RADIUS, {8'd0, mr});
    endtask

    // Hold until every result is back, then let the pipeline settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_radii.size() != 0 || i_in_valid || expected_energy.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic queue_directed();
        pending_radii.push_back(24'd0);
        pending_radii.push_back(24'd1);
        pending_radii.push_back(24'd2);
        pending_radii.push_back(24'hFFFFFF);
        pending_radii.push_back(24'h800000);
        pending_radii.push_back(24'h100000);
        pending_radii.push_back(24'h7FFFFF);
        pending_radii.push_back(min_r - 24'd1);
        pending_radii.push_back(min_r);
        pending_radii.push_back(min_r + 24'd1);
    endtask

    function automatic logic [31:0] rand_coeff();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return 32'($urandom_range(0, 1 << 25)) - (32'd1 << 24);
    endfunction

    function automatic logic [RADIUS_WIDTH-1:0] rand_radius();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom_range(0, 1 << 21));
            2: return 24'($urandom_range(0, 1 << 16));
            default: return min_r + 24'($urandom_range(0, 8)) - 24'd4;
        endcase
    endfunction

    initial begin
        logic [31:0] rate;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_radius    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_out_stall = 1'b0;
        in_took     = 1'b0;
        quiet       = 1'b0;
        hold_send   = 1'b0;
        send_gap    = 0;
        stall_cnt   = 0;
        error_count = 0;
        cycle_count = 0;
        coul_a  = '0;
        lin_b   = '0;
        off_c   = '0;
        gamp_d  = '0;
        grate_e = '0;
        min_r   = 24'd1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Register defaults, then a write to an unmapped index
        pending_radii.push_back(24'd0);
        pending_radii.push_back(24'd1);
        wait_drained();
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);

        // Typical coefficients
        load_coeffs(-32'sd6710886, 32'd15099494, -32'sd5033165, 32'd8388608,
                    32'd33554432, 24'h001000);
        queue_directed();
        wait_drained();

        // Positive extremes, zero minimum radius
        load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 24'd0);
        queue_directed();
        wait_drained();

        // Negative extremes, no rate, maximum minimum radius
        load_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'd0, 24'hFFFFFF);
        queue_directed();
        wait_drained();

        // Random phases, one of them without any idling
        for (int ph = 0; ph < 10; ph++) begin
            case ($urandom_range(0, 2))
                0: rate = $urandom;
                1: rate = $urandom_range(0, 1 << 28);
                default: rate = $urandom_range(0, 1 << 22);
            endcase
            load_coeffs(rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(), rate,
                        ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 1 << 21))
                                                    : 24'($urandom));
            quiet = (ph == 4);
            for (int i = 0; i < 110; i++)
                pending_radii.push_back(rand_radius());
            wait_drained();
            quiet = 1'b0;
        end

        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
hdl/qpe_pkg.sv
hdl/quark_potential_evaluator_unit.sv
tb/tb_quark_potential_evaluator_unit.sv
